[rtl/bwc_pkg.sv]
package bwc_pkg;

    // lattice sides and input fields
    localparam int SIDE_W    = 7;
    localparam logic [SIDE_W-1:0] MAX_SIDE   = 7'd64;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd8;
    localparam int OP_W      = 16;
    localparam int LEG_W     = 4;
    localparam int IN_DATA_W = 24;

    // bond space: up to four planes of lx*ly bonds
    localparam int AREA_W = 2 * SIDE_W;
    localparam int BOND_W = AREA_W + 2;

    // remainder unit: DIV_STEP restoring steps per cycle
    localparam int DIV_W     = BOND_W;
    localparam int DIV_STEP  = 4;
    localparam int DIV_CYC   = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYC - 1);

    // hop counters
    localparam int CNT_W     = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int N_HOP     = 8;
    localparam int HOP_IDX_W = 3;
    typedef logic [HOP_IDX_W-1:0] hop_idx_t;
    localparam hop_idx_t IDX_LEFT  = 3'd0;
    localparam hop_idx_t IDX_RIGHT = 3'd2;
    localparam hop_idx_t IDX_UP    = 3'd4;
    localparam hop_idx_t IDX_DOWN  = 3'd6;
    localparam hop_idx_t TOP_OFS   = 3'd1;

    // result arithmetic
    localparam int WIND_W     = 18;
    localparam int SCL_W      = 27;
    localparam int PROD_W     = 2 * SCL_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int RHO_TT_W   = 47;
    localparam int RHO_W      = 48;
    localparam int OUT_DATA_W = 216;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_ADDR_W-1:0] REG_SIZE_X = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Y = 1'b1;

    localparam int QUEUE_DEPTH_DEF = 4;

    // classified hop event passed from front to back
    typedef struct packed {
        logic     last;
        logic     bump;
        hop_idx_t idx;
    } hop_evt_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASS,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_RUN,
        B_SCALE,
        B_MULT,
        B_SUM
    } back_state_t;

    // zero reads as one, large values as MAX_SIDE
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > MAX_SIDE) begin
            r = MAX_SIDE;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/bilayer_winding_counter_unit.sv]
// Bilayer winding counter. Takes operator-string entries on the s_ stream (one
// beat per entry, s_tlast on the final entry), counts boundary hops of both
// layers in eight saturating 17-bit counters, and on the final entry sends one
// m_ beat with the three weighted winding sums and the four raw windings, and
// clears the counters once their windings are captured. The front holds one
// entry at a time; a hop (odd code, legs one apart) on a bond in the first plane
// of either layer also runs the x-boundary test through a remainder unit that
// resolves 4 bits per cycle. Classified hops cross a small queue to the counter
// side, which updates one counter per cycle; after the final entry the result
// beat is formed in the scale, multiply and sum steps (the last writes the output
// register), and the counter side takes nothing from the queue meanwhile.
// The user must see that size_x and size_y are written through cfg_* while the
// block is idle (not enforced); 0 is taken as 1 and values above 64 as 64.
module bilayer_winding_counter_unit
    import bwc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // operator entries
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // op_code, leg_first, leg_third
    input  logic                  s_tlast,
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // rho_top_top, rho_top_bottom, rho_total,
                                             // wind_x_bottom, wind_y_bottom,
                                             // wind_x_top, wind_y_top, pad
);

    logic [SIDE_W-1:0] size_x_reg, size_y_reg;
    logic [SIDE_W-1:0] lx, ly;
    logic              push_valid, push_ready, pop_valid, pop_ready;
    hop_evt_t          push_evt, pop_evt;

    // size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIDE_RESET;
            size_y_reg <= SIDE_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_SIZE_X) begin
                size_x_reg <= cfg_wr_data;
            end else if (cfg_addr == REG_SIZE_Y) begin
                size_y_reg <= cfg_wr_data;
            end
        end
    end

    assign lx = clamp_side(size_x_reg);
    assign ly = clamp_side(size_y_reg);

    bwc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lx         (lx),
        .ly         (ly),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_evt   (push_evt)
    );

    bwc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_evt   (push_evt),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_evt    (pop_evt)
    );

    bwc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lx        (lx),
        .ly        (ly),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_evt   (pop_evt),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/bwc_front.sv]
module bwc_front
    import bwc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [SIDE_W-1:0]    lx,
    input  logic [SIDE_W-1:0]    ly,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 push_valid,
    input  logic                 push_ready,
    output hop_evt_t             push_evt
);

    front_state_t           state_reg, state_next;
    logic [OP_W-1:0]        op_reg;
    logic [LEG_W-1:0]       leg_a_reg, leg_c_reg;
    logic                   last_reg;
    logic                   dir_lo_reg, layer_reg;
    logic [DIV_W-1:0]       num_reg;
    logic [SIDE_W-1:0]      rem_reg;
    logic [DIV_CNT_W-1:0]   step_reg;

    logic                   off_diag, hop_lo, hop_hi, in_range, countable;
    logic                   layer, x_cand, y_edge;
    logic [BOND_W-1:0]      bond, p1, p2, p3, p4, lx_b, x_num;
    logic [AREA_W-1:0]      area;
    hop_idx_t               y_idx;
    logic [SIDE_W-1:0]      rem_c;
    logic [DIV_W-1:0]       num_c;
    logic [SIDE_W:0]        rem_w;

    // bond classification of the held beat
    always_comb begin
        off_diag  = op_reg[0] && (op_reg[OP_W-1:1] != '0);
        bond      = BOND_W'(op_reg[OP_W-1:1]) - BOND_W'(1);
        area      = AREA_W'(lx) * AREA_W'(ly);
        p1        = BOND_W'(area);
        p2        = p1 << 1;
        p3        = p2 + p1;
        p4        = p1 << 2;
        lx_b      = BOND_W'(lx);
        hop_lo    = ({1'b0, leg_a_reg} + 5'd1) == {1'b0, leg_c_reg};
        hop_hi    = ({1'b0, leg_c_reg} + 5'd1) == {1'b0, leg_a_reg};
        in_range  = bond < p4;
        countable = off_diag && (hop_lo || hop_hi) && in_range;
        layer     = ((bond >= p1) && (bond < p2)) || (bond >= p3);
        // x boundary only possible in the first plane of each layer
        x_cand    = bond < p2;
        y_edge    = layer ? ((bond >= p4 - lx_b) && (bond < p4))
                          : ((bond >= p3 - lx_b) && (bond < p3));
        x_num     = (layer ? (bond - p1) : bond) + BOND_W'(1);
        y_idx     = (hop_lo ? IDX_DOWN : IDX_UP) + (layer ? TOP_OFS : '0);
    end

    // restoring remainder steps, DIV_STEP bits per cycle
    always_comb begin
        rem_c = rem_reg;
        num_c = num_reg;
        rem_w = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            rem_w = {rem_c, num_c[DIV_W-1]};
            num_c = num_c << 1;
            if (rem_w >= {1'b0, lx}) begin
                rem_w = rem_w - {1'b0, lx};
            end
            rem_c = rem_w[SIDE_W-1:0];
        end
    end

    // outputs per state
    always_comb begin
        s_tready   = 1'b0;
        push_valid = 1'b0;
        push_evt   = '{last: last_reg, bump: 1'b0, idx: y_idx};
        unique case (state_reg)
            F_IDLE: begin
                s_tready = 1'b1;
            end
            F_CLASS: begin
                if (!(countable && x_cand)) begin
                    push_evt.bump = countable && y_edge;
                    push_valid    = push_evt.bump || last_reg;
                end
            end
            F_DIV: begin
            end
            F_PUSH: begin
                push_evt.bump = (rem_reg == '0);
                push_evt.idx  = (dir_lo_reg ? IDX_LEFT : IDX_RIGHT)
                              + (layer_reg ? TOP_OFS : '0);
                push_valid    = push_evt.bump || last_reg;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_tvalid) state_next = F_CLASS;
            end
            F_CLASS: begin
                if (countable && x_cand) begin
                    state_next = F_DIV;
                end else if (!push_valid || push_ready) begin
                    state_next = F_IDLE;
                end
            end
            F_DIV: begin
                if (step_reg == DIV_LAST) state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!push_valid || push_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == F_DIV) begin
                step_reg <= step_reg + DIV_CNT_W'(1);
            end else begin
                step_reg <= '0;
            end
        end
    end

    // beat and remainder payload
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_tvalid) begin
            op_reg    <= s_tdata[OP_W-1:0];
            leg_a_reg <= s_tdata[OP_W+LEG_W-1:OP_W];
            leg_c_reg <= s_tdata[OP_W+2*LEG_W-1:OP_W+LEG_W];
            last_reg  <= s_tlast;
        end
        if (state_reg == F_CLASS) begin
            num_reg    <= x_num;
            rem_reg    <= '0;
            dir_lo_reg <= hop_lo;
            layer_reg  <= layer;
        end else if (state_reg == F_DIV) begin
            num_reg <= num_c;
            rem_reg <= rem_c;
        end
    end

endmodule

[rtl/bwc_queue.sv]
module bwc_queue
    import bwc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  hop_evt_t push_evt,
    output logic     pop_valid,
    input  logic     pop_ready,
    output hop_evt_t pop_evt
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    hop_evt_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic                do_push, do_pop;

    assign push_ready = fill_reg != FILL_W'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_evt    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_evt;
    end

endmodule

[rtl/bwc_back.sv]
module bwc_back
    import bwc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [SIDE_W-1:0]     lx,
    input  logic [SIDE_W-1:0]     ly,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  hop_evt_t              pop_evt,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    back_state_t                state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg [N_HOP];
    logic signed [WIND_W-1:0]   w_xb_reg, w_yb_reg, w_xt_reg, w_yt_reg;
    logic signed [SCL_W-1:0]    s_xt_reg, s_xb_reg, s_xs_reg, s_yt_reg, s_yb_reg, s_ys_reg;
    logic signed [PROD_W-1:0]   p_xtt_reg, p_xtb_reg, p_xss_reg;
    logic signed [PROD_W-1:0]   p_ytt_reg, p_ytb_reg, p_yss_reg;
    logic                       m_valid_reg;
    logic [OUT_DATA_W-1:0]      m_data_reg;

    logic                       out_free, load_out, clear_cnt, do_pop;
    logic signed [WIND_W-1:0]   w_xb, w_yb, w_xt, w_yt;
    logic signed [SCL_W-1:0]    lx_s, ly_s, e_xb, e_yb, e_xt, e_yt;
    logic signed [SUM_W-1:0]    tt_sum, tb_sum, tot_sum;
    logic [RHO_TT_W-1:0]        tt_out;
    logic [RHO_W-1:0]           tb_out, tot_out;

    assign out_free = !m_valid_reg || m_tready;
    assign do_pop   = pop_valid && pop_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // windings from the counters
    always_comb begin
        w_xb = $signed({1'b0, cnt_reg[IDX_LEFT]})  - $signed({1'b0, cnt_reg[IDX_RIGHT]});
        w_xt = $signed({1'b0, cnt_reg[IDX_LEFT + TOP_OFS]})
             - $signed({1'b0, cnt_reg[IDX_RIGHT + TOP_OFS]});
        w_yb = $signed({1'b0, cnt_reg[IDX_UP]})    - $signed({1'b0, cnt_reg[IDX_DOWN]});
        w_yt = $signed({1'b0, cnt_reg[IDX_UP + TOP_OFS]})
             - $signed({1'b0, cnt_reg[IDX_DOWN + TOP_OFS]});
        lx_s = $signed({{(SCL_W-SIDE_W){1'b0}}, lx});
        ly_s = $signed({{(SCL_W-SIDE_W){1'b0}}, ly});
        e_xb = $signed({{(SCL_W-WIND_W){w_xb[WIND_W-1]}}, w_xb});
        e_xt = $signed({{(SCL_W-WIND_W){w_xt[WIND_W-1]}}, w_xt});
        e_yb = $signed({{(SCL_W-WIND_W){w_yb[WIND_W-1]}}, w_yb});
        e_yt = $signed({{(SCL_W-WIND_W){w_yt[WIND_W-1]}}, w_yt});
    end

    // final sums and saturation
    always_comb begin
        tt_sum  = $signed({p_xtt_reg[PROD_W-1], p_xtt_reg})
                + $signed({p_ytt_reg[PROD_W-1], p_ytt_reg});
        tb_sum  = $signed({p_xtb_reg[PROD_W-1], p_xtb_reg})
                + $signed({p_ytb_reg[PROD_W-1], p_ytb_reg});
        tot_sum = $signed({p_xss_reg[PROD_W-1], p_xss_reg})
                + $signed({p_yss_reg[PROD_W-1], p_yss_reg});
        // squares are never negative
        tt_out  = (tt_sum[SUM_W-1:RHO_TT_W] != '0) ? '1 : tt_sum[RHO_TT_W-1:0];
        tot_out = (tot_sum[SUM_W-1:RHO_W] != '0) ? '1 : tot_sum[RHO_W-1:0];
        if ((tb_sum[SUM_W-1:RHO_W-1] == '0) || (tb_sum[SUM_W-1:RHO_W-1] == '1)) begin
            tb_out = tb_sum[RHO_W-1:0];
        end else if (tb_sum[SUM_W-1]) begin
            tb_out = {1'b1, {(RHO_W-1){1'b0}}};
        end else begin
            tb_out = {1'b0, {(RHO_W-1){1'b1}}};
        end
    end

    // outputs per state
    always_comb begin
        pop_ready = 1'b0;
        clear_cnt = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            B_RUN:   pop_ready = 1'b1;
            B_SCALE: clear_cnt = 1'b1;
            B_MULT:  begin
            end
            B_SUM:   load_out  = out_free;
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_RUN: begin
                if (pop_valid && pop_evt.last) state_next = B_SCALE;
            end
            B_SCALE: state_next = B_MULT;
            B_MULT:  state_next = B_SUM;
            B_SUM: begin
                if (out_free) state_next = B_RUN;
            end
            default: state_next = B_RUN;
        endcase
    end

    // control state, hop counters, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_RUN;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < N_HOP; i++) cnt_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (clear_cnt) begin
                for (int i = 0; i < N_HOP; i++) cnt_reg[i] <= '0;
            end else if (do_pop && pop_evt.bump && cnt_reg[pop_evt.idx] != CNT_MAX) begin
                cnt_reg[pop_evt.idx] <= cnt_reg[pop_evt.idx] + CNT_W'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result datapath: scale, multiply, sum
    always_ff @(posedge aclk) begin
        if (state_reg == B_SCALE) begin
            w_xb_reg <= w_xb;
            w_yb_reg <= w_yb;
            w_xt_reg <= w_xt;
            w_yt_reg <= w_yt;
            s_xt_reg <= lx_s * e_xt;
            s_xb_reg <= lx_s * e_xb;
            s_xs_reg <= lx_s * (e_xb + e_xt);
            s_yt_reg <= ly_s * e_yt;
            s_yb_reg <= ly_s * e_yb;
            s_ys_reg <= ly_s * (e_yb + e_yt);
        end
        if (state_reg == B_MULT) begin
            p_xtt_reg <= PROD_W'(s_xt_reg) * PROD_W'(s_xt_reg);
            p_xtb_reg <= PROD_W'(s_xt_reg) * PROD_W'(s_xb_reg);
            p_xss_reg <= PROD_W'(s_xs_reg) * PROD_W'(s_xs_reg);
            p_ytt_reg <= PROD_W'(s_yt_reg) * PROD_W'(s_yt_reg);
            p_ytb_reg <= PROD_W'(s_yt_reg) * PROD_W'(s_yb_reg);
            p_yss_reg <= PROD_W'(s_ys_reg) * PROD_W'(s_ys_reg);
        end
        if (load_out) begin
            m_data_reg <= {1'b0, w_yt_reg, w_xt_reg, w_yb_reg, w_xb_reg,
                           tot_out, tb_out, tt_out};
        end
    end

endmodule

[rtl/bwc_checker.sv]
module bwc_checker
    import bwc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // nothing comes out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // the front works on one entry at a time
    a_front_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("entry accepted while the previous one is in work");

    // zero top windings give zero top sums
    a_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[196:179] == '0) && (m_tdata[214:197] == '0)
        |-> (m_tdata[46:0] == '0) && (m_tdata[94:47] == '0))
        else $error("top sums nonzero with zero top windings");

    // a zero total sum means both summed windings are zero
    a_total_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[142:95] == '0)
        |-> (18'(m_tdata[160:143] + m_tdata[196:179]) == '0)
         && (18'(m_tdata[178:161] + m_tdata[214:197]) == '0))
        else $error("total sum zero with nonzero summed winding");

endmodule

bind bilayer_winding_counter_unit bwc_checker u_bwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
